// ===== design/pcsh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsh_pkg
// Shared types, codes and constants of the program-counter histogram block.
// ----------------------------------------------------------------------------
package pcsh_pkg;

  localparam int NUM_BINS_DEF = 4096;
  localparam int NUM_CPUS_DEF = 8;

  localparam int DATA_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int RIDX_W   = 13;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PROFILE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SHIFT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_BASE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CPU_ENABLE_MASK = 3'd4;

  // opcodes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // profile modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_SCHED = 2'd2;

  // result status codes
  localparam logic [2:0] ST_COUNTED  = 3'd0;
  localparam logic [2:0] ST_IGNORED  = 3'd1;
  localparam logic [2:0] ST_READ_OK  = 3'd2;
  localparam logic [2:0] ST_READ_END = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  // register reset values
  localparam logic [12:0] BIN_COUNT_RST = 13'd4096;
  localparam logic [7:0]  CPU_MASK_RST  = 8'hFF;

  typedef struct packed {
    logic [1:0]        profile_mode;
    logic [4:0]        bin_shift;
    logic [DATA_W-1:0] text_base;
    logic [12:0]       bin_count;
    logic [7:0]        cpu_enable_mask;
  } cfg_t;

endpackage

// ===== design/pcsh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsh_if
// Valid/ready channels of the histogram block: request and response.
// ----------------------------------------------------------------------------
interface pcsh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  hit_type;
  logic [31:0] pc;
  logic        in_user_mode;
  logic [2:0]  cpu_id;
  logic [12:0] read_index;

  modport source (
    output valid, opcode, hit_type, pc, in_user_mode, cpu_id, read_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, hit_type, pc, in_user_mode, cpu_id, read_index,
    output ready
  );
endinterface

interface pcsh_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] read_data;

  modport source (
    output valid, status, read_data,
    input  ready
  );
  modport sink (
    input  valid, status, read_data,
    output ready
  );
endinterface

// ===== design/pcsh_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsh_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pcsh_cfg
  import pcsh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.profile_mode    <= MODE_OFF;
      cfg.bin_shift       <= 5'd0;
      cfg.text_base       <= '0;
      cfg.bin_count       <= BIN_COUNT_RST;
      cfg.cpu_enable_mask <= CPU_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROFILE_MODE:    cfg.profile_mode    <= cfg_wdata[1:0];
        REG_BIN_SHIFT:       cfg.bin_shift       <= cfg_wdata[4:0];
        REG_TEXT_BASE:       cfg.text_base       <= cfg_wdata;
        REG_BIN_COUNT:       cfg.bin_count       <= cfg_wdata[12:0];
        REG_CPU_ENABLE_MASK: cfg.cpu_enable_mask <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pcsh_bin_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsh_bin_ram
// Bin counter store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcsh_bin_ram
  import pcsh_pkg::*;
#(
  parameter int DEPTH  = NUM_BINS_DEF,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/pcsh_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsh_engine
// Sequencer: qualifies samples, forms bin addresses, runs the read-modify-
// write on the bin store, sweeps the store clear and holds the response.
// ----------------------------------------------------------------------------
module pcsh_engine
  import pcsh_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF,
  parameter int NUM_CPUS = NUM_CPUS_DEF,
  parameter int IDX_W    = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  // request side
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        req_opcode,
  input  logic [1:0]        req_hit_type,
  input  logic [31:0]       req_pc,
  input  logic              req_user,
  input  logic [2:0]        req_cpu_id,
  input  logic [RIDX_W-1:0] req_read_index,
  // response side
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [2:0]        rsp_status,
  output logic [DATA_W-1:0] rsp_data,
  // bin store
  output logic              ram_we,
  output logic [IDX_W-1:0]  ram_waddr,
  output logic [DATA_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [IDX_W-1:0]  ram_raddr,
  input  logic [DATA_W-1:0] ram_rdata
);

  localparam int LIM_W = ($clog2(NUM_BINS + 1) > RIDX_W) ? $clog2(NUM_BINS + 1) : RIDX_W;
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NUM_BINS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DATA = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  logic [2:0]        state;
  logic [1:0]        opcode;
  logic [1:0]        hit_type;
  logic [31:0]       pc;
  logic              user;
  logic [2:0]        cpu_id;
  logic [RIDX_W-1:0] read_index;
  logic              is_count;
  logic [IDX_W-1:0]  addr;
  logic [IDX_W-1:0]  clr_addr;
  logic              clr_item;
  logic [2:0]        res_status;
  logic [DATA_W-1:0] res_data;

  logic [LIM_W-1:0]  limit;
  logic [31:0]       offset;
  logic [31:0]       bin_raw;
  logic [31:0]       last_bin;
  logic              sample_ok;
  logic [IDX_W-1:0]  sample_addr;

  // bins in use, clamped to 1..NUM_BINS
  always_comb begin
    if (cfg.bin_count == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(cfg.bin_count) > LIM_W'(NUM_BINS)) begin
      limit = LIM_W'(NUM_BINS);
    end else begin
      limit = LIM_W'(cfg.bin_count);
    end
  end

  assign offset   = pc - cfg.text_base;
  assign bin_raw  = offset >> cfg.bin_shift;
  assign last_bin = 32'(limit - LIM_W'(1));
  assign sample_addr = (bin_raw > last_bin) ? IDX_W'(last_bin) : IDX_W'(bin_raw);

  assign sample_ok = !user
                  && (32'(cpu_id) < NUM_CPUS)
                  && cfg.cpu_enable_mask[cpu_id]
                  && (cfg.profile_mode == MODE_TICK || cfg.profile_mode == MODE_SCHED)
                  && (hit_type == cfg.profile_mode);

  assign req_ready = (state == S_IDLE);

  assign ram_re    = (state == S_RD);
  assign ram_raddr = addr;
  assign ram_we    = (state == S_CLR) || ((state == S_DATA) && is_count);
  assign ram_waddr = (state == S_CLR) ? clr_addr : addr;
  assign ram_wdata = (state == S_CLR) ? '0 : ram_rdata + DATA_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      clr_item  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          case (opcode)
            OP_SAMPLE: state <= sample_ok ? S_RD : S_OUT;
            OP_READ: begin
              if (read_index != '0 && LIM_W'(read_index) <= limit) begin
                state <= S_RD;
              end else begin
                state <= S_OUT;
              end
            end
            OP_CLEAR: begin
              state    <= S_CLR;
              clr_addr <= '0;
              clr_item <= 1'b1;
            end
            default: state <= S_OUT;
          endcase
        end
        S_RD:   state <= S_DATA;
        S_DATA: state <= S_OUT;
        S_OUT: begin
          // response register must be free or draining this cycle
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_CLR: begin
          if (clr_addr == LAST_ADDR) begin
            state <= clr_item ? S_OUT : S_IDLE;
          end else begin
            clr_addr <= clr_addr + IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      opcode     <= req_opcode;
      hit_type   <= req_hit_type;
      pc         <= req_pc;
      user       <= req_user;
      cpu_id     <= req_cpu_id;
      read_index <= req_read_index;
    end
    if (state == S_ADDR) begin
      is_count <= 1'b0;
      res_data <= '0;
      case (opcode)
        OP_SAMPLE: begin
          is_count   <= sample_ok;
          addr       <= sample_addr;
          res_status <= sample_ok ? ST_COUNTED : ST_IGNORED;
        end
        OP_READ: begin
          addr <= IDX_W'(read_index - RIDX_W'(1));
          if (read_index == '0) begin
            res_data   <= DATA_W'(1) << cfg.bin_shift;
            res_status <= ST_READ_OK;
          end else if (LIM_W'(read_index) <= limit) begin
            res_status <= ST_READ_OK;
          end else begin
            res_status <= ST_READ_END;
          end
        end
        OP_CLEAR: res_status <= ST_CLEARED;
        default:  res_status <= ST_IGNORED;
      endcase
    end
    // read data lands in the cycle after the store read
    if (state == S_DATA && !is_count) begin
      res_data <= ram_rdata;
    end
    if (state == S_OUT && (!rsp_valid || rsp_ready)) begin
      rsp_status <= res_status;
      rsp_data   <= res_data;
    end
  end

endmodule

// ===== design/pc_sample_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_sample_histogram
// Program-counter histogram profiler with a clearable bin counter store.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per item: a sample hit, a word read or a clear.
//   rsp returns exactly one transaction per item with status and read_data.
//   cfg_we/cfg_index/cfg_wdata write the five configuration registers; write
//   them only while no item is in flight.
// Item flow:
//   after acceptance a sample or an in-range read passes the address stage,
//   store read, read data and response load; ignored samples and reads
//   without store access go from the address stage to the response load.
//   A clear sweeps the store one entry per cycle.
//   One item is in flight at a time; the next one is accepted in the cycle
//   after the response loads. The next item is accepted while a response
//   waits.
// Reset:
//   registers return to their defaults and the store is swept to zero,
//   during which req.ready stays low.
// Stall:
//   while rsp.ready is low the response is held and the block stops after
//   finishing the next item, with that result waiting to load.
// ----------------------------------------------------------------------------
module pc_sample_histogram
  import pcsh_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF,
  parameter int NUM_CPUS = NUM_CPUS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  pcsh_req_if.sink             req,
  pcsh_rsp_if.source           rsp
);

  localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  cfg_t              cfg;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  pcsh_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcsh_bin_ram #(
    .DEPTH  (NUM_BINS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pcsh_engine #(
    .NUM_BINS (NUM_BINS),
    .NUM_CPUS (NUM_CPUS),
    .IDX_W    (IDX_W)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_opcode     (req.opcode),
    .req_hit_type   (req.hit_type),
    .req_pc         (req.pc),
    .req_user       (req.in_user_mode),
    .req_cpu_id     (req.cpu_id),
    .req_read_index (req.read_index),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_data       (rsp.read_data),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

endmodule

// ===== tb/pc_sample_histogram_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_sample_histogram_test
// Self-checking bench for the program-counter histogram block. A scripted
// table covers register defaults, field extremes and every opcode. Random
// phases follow, each under its own register setting. A shadow histogram
// predicts each response that the table leaves open, and responses are compared in order.
// ----------------------------------------------------------------------------
module pc_sample_histogram_test;
  import pcsh_pkg::*;

  localparam int NUM_BINS    = NUM_BINS_DEF;
  localparam int NUM_CPUS    = NUM_CPUS_DEF;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 128;
  localparam int HOLD_CYCLES = 300;
  localparam int SCRIPT_LEN  = 27;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] MODE_BAD  = 2'd3;
  localparam logic [1:0] HIT_NONE  = 2'd0;
  localparam logic [1:0] HIT_TICK  = 2'd1;
  localparam logic [1:0] HIT_SCHED = 2'd2;
  localparam logic [1:0] HIT_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [1:0]        hit_type;
    logic [DATA_W-1:0] pc;
    logic              in_user_mode;
    logic [2:0]        cpu_id;
    logic [RIDX_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [DATA_W-1:0] read_data;
  } result_t;

  typedef struct packed {
    logic    is_cfg;
    cfg_t    cfg;
    req_t    item;
    logic    typed;
    result_t want;
  } step_row_t;

  localparam cfg_t    NO_CFG    = '0;
  localparam req_t    NO_ITEM   = '0;
  localparam result_t NO_RESULT = '0;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  pcsh_req_if req ();
  pcsh_rsp_if rsp ();

  pc_sample_histogram dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // shadow of the block: bin store and register settings
  logic [DATA_W-1:0] bin_model [NUM_BINS];
  cfg_t              model_cfg;
  result_t           awaited_results [$];
  int                mismatch_count = 0;
  int                req_max_gap    = 8;
  int                rsp_max_stall  = 8;
  bit                rsp_hold       = 1'b0;

  step_row_t script [SCRIPT_LEN] = '{
    // reset settings: profiling off, full store
    '{1'b0, NO_CFG, '{OP_SAMPLE, HIT_TICK, 32'h0000_0000, 1'b0, 3'd0, 13'd0},
      1'b1, '{ST_IGNORED, 32'd0}},
    '{1'b0, NO_CFG, '{OP_READ, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd0},
      1'b1, '{ST_READ_OK, 32'd1}},
    '{1'b0, NO_CFG, '{OP_READ, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd1},
      1'b1, '{ST_READ_OK, 32'd0}},
    '{1'b0, NO_CFG, '{OP_READ, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd4096},
      1'b1, '{ST_READ_OK, 32'd0}},
    '{1'b0, NO_CFG, '{OP_READ, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd4097},
      1'b1, '{ST_READ_END, 32'd0}},
    '{1'b0, NO_CFG, '{OP_UNUSED, HIT_BAD, 32'hFFFF_FFFF, 1'b1, 3'd7, 13'h1FFF},
      1'b1, '{ST_IGNORED, 32'd0}},
    '{1'b0, NO_CFG, '{OP_CLEAR, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd0},
      1'b1, '{ST_CLEARED, 32'd0}},
    // tick profiling, 16 bins, cpus 0 and 7 enabled
    '{1'b1, '{MODE_TICK, 5'd0, 32'h0000_1000, 13'd16, 8'h81}, NO_ITEM, 1'b0, NO_RESULT},
    '{1'b0, NO_CFG, '{OP_SAMPLE, HIT_TICK, 32'h0000_1000, 1'b0, 3'd0, 13'd0},
      1'b1, '{ST_COUNTED, 32'd0}},
    '{1'b0, NO_CFG, '{OP_SAMPLE, HIT_TICK, 32'h0000_0FFF, 1'b0, 3'd7, 13'd0},
      1'b0, NO_RESULT},
    '{1'b0, NO_CFG, '{OP_SAMPLE, HIT_TICK, 32'hFFFF_FFFF, 1'b0, 3'd0, 13'd0},
      1'b0, NO_RESULT},
    '{1'b0, NO_CFG, '{OP_SAMPLE, HIT_TICK, 32'h0000_1005, 1'b1, 3'd0, 13'd0},
      1'b1, '{ST_IGNORED, 32'd0}},
    '{1'b0, NO_CFG, '{OP_SAMPLE, HIT_TICK, 32'h0000_1005, 1'b0, 3'd4, 13'd0},
      1'b1, '{ST_IGNORED, 32'd0}},
    '{1'b0, NO_CFG, '{OP_SAMPLE, HIT_SCHED, 32'h0000_1005, 1'b0, 3'd0, 13'd0},
      1'b1, '{ST_IGNORED, 32'd0}},
    '{1'b0, NO_CFG, '{OP_SAMPLE, HIT_BAD, 32'h0000_1005, 1'b0, 3'd0, 13'd0},
      1'b1, '{ST_IGNORED, 32'd0}},
    '{1'b0, NO_CFG, '{OP_READ, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd1},
      1'b0, NO_RESULT},
    '{1'b0, NO_CFG, '{OP_READ, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd16},
      1'b0, NO_RESULT},
    '{1'b0, NO_CFG, '{OP_READ, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd17},
      1'b1, '{ST_READ_END, 32'd0}},
    // schedule profiling, widest shift, zero bin count acts as one bin
    '{1'b1, '{MODE_SCHED, 5'd31, 32'hFFFF_FFFF, 13'd0, 8'h7F}, NO_ITEM, 1'b0, NO_RESULT},
    '{1'b0, NO_CFG, '{OP_SAMPLE, HIT_SCHED, 32'h7FFF_FFFF, 1'b0, 3'd6, 13'd0},
      1'b0, NO_RESULT},
    '{1'b0, NO_CFG, '{OP_SAMPLE, HIT_SCHED, 32'h7FFF_FFFF, 1'b0, 3'd7, 13'd0},
      1'b1, '{ST_IGNORED, 32'd0}},
    '{1'b0, NO_CFG, '{OP_READ, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd0},
      1'b1, '{ST_READ_OK, 32'h8000_0000}},
    '{1'b0, NO_CFG, '{OP_READ, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd1},
      1'b0, NO_RESULT},
    '{1'b0, NO_CFG, '{OP_READ, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd2},
      1'b1, '{ST_READ_END, 32'd0}},
    // mode 3 has no meaning: a matching hit type still counts nothing
    '{1'b1, '{MODE_BAD, 5'd4, 32'h0000_0000, 13'h1FFF, 8'hFF}, NO_ITEM, 1'b0, NO_RESULT},
    '{1'b0, NO_CFG, '{OP_SAMPLE, HIT_BAD, 32'h0000_0010, 1'b0, 3'd0, 13'd0},
      1'b1, '{ST_IGNORED, 32'd0}},
    '{1'b0, NO_CFG, '{OP_CLEAR, HIT_NONE, 32'h0000_0000, 1'b0, 3'd0, 13'd0},
      1'b1, '{ST_CLEARED, 32'd0}}
  };

  function automatic int unsigned bins_in_play();
    if (model_cfg.bin_count == '0) return 1;
    if (model_cfg.bin_count > NUM_BINS) return NUM_BINS;
    return model_cfg.bin_count;
  endfunction

  // next response of the block for one transaction; updates the shadow store
  function automatic result_t histogram_step(req_t r);
    result_t           res;
    logic [DATA_W-1:0] idx;
    int unsigned       used;
    res  = NO_RESULT;
    res.status = ST_IGNORED;
    used = bins_in_play();
    case (r.opcode)
      OP_SAMPLE: begin
        if (!r.in_user_mode && r.cpu_id < NUM_CPUS && model_cfg.cpu_enable_mask[r.cpu_id]
            && (model_cfg.profile_mode == MODE_TICK || model_cfg.profile_mode == MODE_SCHED)
            && r.hit_type == model_cfg.profile_mode) begin
          idx = (r.pc - model_cfg.text_base) >> model_cfg.bin_shift;
          if (idx > used - 1) idx = used - 1;
          bin_model[idx] = bin_model[idx] + 1'b1;
          res.status = ST_COUNTED;
        end
      end
      OP_READ: begin
        if (r.read_index == '0) begin
          res.read_data = 32'd1 << model_cfg.bin_shift;
          res.status    = ST_READ_OK;
        end else if (r.read_index <= used) begin
          res.read_data = bin_model[r.read_index - 1];
          res.status    = ST_READ_OK;
        end else begin
          res.status = ST_READ_END;
        end
      end
      OP_CLEAR: begin
        foreach (bin_model[i]) bin_model[i] = '0;
        res.status = ST_CLEARED;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(req_t it, logic typed, result_t want);
    int      gap;
    result_t predicted;
    gap = $urandom_range(0, req_max_gap);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.opcode       <= it.opcode;
    req.hit_type     <= it.hit_type;
    req.pc           <= it.pc;
    req.in_user_mode <= it.in_user_mode;
    req.cpu_id       <= it.cpu_id;
    req.read_index   <= it.read_index;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    predicted = histogram_step(it);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    put_reg(REG_PROFILE_MODE, DATA_W'(c.profile_mode));
    put_reg(REG_BIN_SHIFT, DATA_W'(c.bin_shift));
    put_reg(REG_TEXT_BASE, c.text_base);
    put_reg(REG_BIN_COUNT, DATA_W'(c.bin_count));
    put_reg(REG_CPU_ENABLE_MASK, DATA_W'(c.cpu_enable_mask));
    cfg_we    <= 1'b0;
    model_cfg  = c;
  endtask

  // response side: random stalls, one long hold-off on request
  initial begin : response_check
    int      stall;
    result_t want;
    rsp.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = $urandom_range(0, rsp_max_stall);
      if (rsp_hold) begin
        stall    = HOLD_CYCLES;
        rsp_hold = 1'b0;
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (rsp.valid !== 1'b1) @(posedge clk);
      if (awaited_results.size() == 0) begin
        $error("unexpected response: status %0d read_data 0x%08h", rsp.status, rsp.read_data);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.read_data !== want.read_data) begin
          $error("read_data: expected 0x%08h, got 0x%08h", want.read_data, rsp.read_data);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    req_t        it;
    cfg_t        cfg;
    int unsigned nb;
    int          pick;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    req.valid        = 1'b0;
    req.opcode       = OP_SAMPLE;
    req.hit_type     = HIT_NONE;
    req.pc           = '0;
    req.in_user_mode = 1'b0;
    req.cpu_id       = '0;
    req.read_index   = '0;
    foreach (bin_model[i]) bin_model[i] = '0;
    model_cfg = '{MODE_OFF, 5'd0, 32'd0, BIN_COUNT_RST, CPU_MASK_RST};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain();
        load_config(script[i].cfg);
      end else begin
        send_item(script[i].item, script[i].typed, script[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      cfg.profile_mode = (phase % 2 == 0) ? MODE_TICK : MODE_SCHED;
      if (phase == 5) cfg.profile_mode = MODE_OFF;
      if (phase == 7) cfg.profile_mode = MODE_BAD;
      case (phase)
        0:       cfg.bin_shift = 5'd0;
        1:       cfg.bin_shift = 5'd31;
        default: cfg.bin_shift = 5'($urandom_range(0, 12));
      endcase
      cfg.text_base = (phase == 3) ? 32'hFFFF_FFFF : ((phase == 0) ? 32'd0 : $urandom);
      case (phase)
        0:       cfg.bin_count = 13'd4096;
        1:       cfg.bin_count = 13'd0;
        2:       cfg.bin_count = 13'h1FFF;
        3:       cfg.bin_count = 13'd1;
        default: cfg.bin_count = 13'($urandom_range(2, 64));
      endcase
      case (phase)
        0:       cfg.cpu_enable_mask = 8'hFF;
        4:       cfg.cpu_enable_mask = 8'h00;
        default: cfg.cpu_enable_mask = 8'($urandom_range(0, 255));
      endcase
      load_config(cfg);
      req_max_gap   = (phase % 3 == 2) ? 0 : 8;
      rsp_max_stall = (phase % 4 == 2) ? 0 : 8;
      // fill the block up while the response side holds off
      if (phase == 1) rsp_hold = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        nb                = bins_in_play();
        it.opcode         = 2'($urandom_range(0, 3));
        it.hit_type       = 2'($urandom_range(0, 3));
        it.pc             = $urandom;
        it.in_user_mode   = 1'($urandom_range(0, 1));
        it.cpu_id         = 3'($urandom_range(0, 7));
        it.read_index     = RIDX_W'($urandom_range(0, 8191));
        pick              = $urandom_range(0, 99);
        if (pick < 60) begin
          // well-formed sample aimed at the bins in use and just beyond them
          it.opcode = OP_SAMPLE;
          if (model_cfg.profile_mode == MODE_TICK || model_cfg.profile_mode == MODE_SCHED)
            it.hit_type = model_cfg.profile_mode;
          it.in_user_mode = 1'b0;
          if (model_cfg.cpu_enable_mask != '0)
            while (!model_cfg.cpu_enable_mask[it.cpu_id]) it.cpu_id = 3'($urandom_range(0, 7));
          it.pc = model_cfg.text_base
                + (DATA_W'($urandom_range(0, nb + 1)) << model_cfg.bin_shift)
                + ($urandom & ((32'd1 << model_cfg.bin_shift) - 32'd1));
        end else if (pick < 75) begin
          it.opcode = OP_SAMPLE;
        end else if (pick < 95) begin
          it.opcode = OP_READ;
          if ($urandom_range(0, 4) != 0) it.read_index = RIDX_W'($urandom_range(0, nb + 1));
        end else if (pick < 97) begin
          it.opcode = OP_CLEAR;
        end else begin
          it.opcode = OP_UNUSED;
        end
        send_item(it, 1'b0, NO_RESULT);
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pc_sample_histogram test passed");
    end else begin
      $display("pc_sample_histogram test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(4_000_000);
    $display("pc_sample_histogram test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pcsh_pkg.sv
design/pcsh_if.sv
design/pcsh_cfg.sv
design/pcsh_bin_ram.sv
design/pcsh_engine.sv
design/pc_sample_histogram.sv
tb/pc_sample_histogram_test.sv
